// ----- rtl/core/rcn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_pkg: shared types and constants for the rotation compose block
// Payload structs, inter-stage structs and pipeline depth constants.
// ----------------------------------------------------------------------------
package rcn_pkg;

   localparam int SQ_STEPS   = 32;   // one root bit per stage
   localparam int DIV_STEPS  = 15;   // one quotient bit per stage
   localparam int FRONT_LAT  = 4;    // products, sums, squares, compare
   localparam int TOTAL_LAT  = FRONT_LAT + SQ_STEPS + DIV_STEPS + 1;

   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] a_cos;
      logic signed [15:0] a_sin;
      logic signed [15:0] b_cos;
      logic signed [15:0] b_sin;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_cos;
      logic signed [15:0] out_sin;
      logic               degenerate;
   } rsp_type;

   // Per-item facts that ride alongside the root and divide pipelines.
   typedef struct packed {
      logic        x_neg;
      logic        y_neg;
      logic [31:0] ux;
      logic [31:0] uy;
      logic        degen;
   } side_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] n;
      logic [63:0] res;
      side_type    side;
   } sq_stage_type;

   typedef struct packed {
      logic        valid;
      logic [47:0] rem_c;
      logic [47:0] rem_s;
      logic [14:0] q_c;
      logic [14:0] q_s;
      logic [32:0] d;
      logic        x_neg;
      logic        y_neg;
      logic        degen;
   } div_stage_type;

endpackage

// ----- rtl/core/rcn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_front: complex product, squared magnitude and epsilon test
// Four register stages ending in the radicand and its side information.
// ----------------------------------------------------------------------------
module rcn_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rcn_pkg::req_type      in_data,
   input  logic [14:0]           epsilon,
   output rcn_pkg::sq_stage_type out_stage
);

   // Stage 1: the four partial products.
   logic               v1_ff;
   logic signed [31:0] p_cc_ff, p_ss_ff, p_cs_ff, p_sc_ff;
   // Stage 2: real and imaginary parts as sign and magnitude.
   logic               v2_ff;
   logic               xn_ff, yn_ff;
   logic [31:0]        ux_ff, uy_ff;
   // Stage 3: squares and the squared threshold.
   logic               v3_ff;
   logic               xn3_ff, yn3_ff;
   logic [31:0]        ux3_ff, uy3_ff;
   logic [63:0]        sqx_ff, sqy_ff;
   logic [29:0]        eps2_ff;
   // Stage 4 is the output struct.
   rcn_pkg::sq_stage_type out_ff;

   logic signed [32:0] x_in, y_in;
   logic [63:0]        sum_in;

   always_comb begin
      x_in   = 33'(p_cc_ff) - 33'(p_ss_ff);
      y_in   = 33'(p_cs_ff) + 33'(p_sc_ff);
      sum_in = sqx_ff + sqy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_ff.valid <= v3_ff;
      end
      p_cc_ff <= in_data.a_cos * in_data.b_cos;
      p_ss_ff <= in_data.a_sin * in_data.b_sin;
      p_cs_ff <= in_data.a_cos * in_data.b_sin;
      p_sc_ff <= in_data.a_sin * in_data.b_cos;

      xn_ff <= x_in[32];
      yn_ff <= y_in[32];
      ux_ff <= x_in[32] ? 32'(-x_in) : x_in[31:0];
      uy_ff <= y_in[32] ? 32'(-y_in) : y_in[31:0];

      xn3_ff  <= xn_ff;
      yn3_ff  <= yn_ff;
      ux3_ff  <= ux_ff;
      uy3_ff  <= uy_ff;
      sqx_ff  <= 64'(ux_ff) * 64'(ux_ff);
      sqy_ff  <= 64'(uy_ff) * 64'(uy_ff);
      eps2_ff <= 30'(epsilon) * 30'(epsilon);

      out_ff.n          <= sum_in;
      out_ff.res        <= 64'd0;
      out_ff.side.x_neg <= xn3_ff;
      out_ff.side.y_neg <= yn3_ff;
      out_ff.side.ux    <= ux3_ff;
      out_ff.side.uy    <= uy3_ff;
      out_ff.side.degen <= (sum_in <= {6'd0, eps2_ff, 28'd0});
   end

   assign out_stage = out_ff;

endmodule

// ----- rtl/core/rcn_sqrt_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_sqrt_pipe: pipelined integer square root
// Digit-by-digit root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module rcn_sqrt_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  rcn_pkg::sq_stage_type in_stage,
   output rcn_pkg::sq_stage_type out_stage
);

   rcn_pkg::sq_stage_type stg_ff [rcn_pkg::SQ_STEPS];

   for (genvar i = 0; i < rcn_pkg::SQ_STEPS; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      rcn_pkg::sq_stage_type cur;
      rcn_pkg::sq_stage_type nxt_in;
      logic [63:0]           trial;

      if (i == 0) begin : g_first
         assign cur = in_stage;
      end else begin : g_rest
         assign cur = stg_ff[i - 1];
      end

      always_comb begin
         nxt_in = cur;
         trial  = cur.res + BIT;
         if (cur.n >= trial) begin
            nxt_in.n   = cur.n - trial;
            nxt_in.res = (cur.res >> 1) + BIT;
         end else begin
            nxt_in.res = cur.res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[i] <= '0;
         end else begin
            stg_ff[i] <= nxt_in;
         end
      end
   end

   assign out_stage = stg_ff[rcn_pkg::SQ_STEPS - 1];

endmodule

// ----- rtl/core/rcn_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcn_div_pipe: two-lane pipelined rounding divider
// Forms round(mag * 2^14 / r) for both parts, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rcn_div_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  rcn_pkg::sq_stage_type  in_stage,
   output rcn_pkg::div_stage_type out_stage
);

   rcn_pkg::div_stage_type stg_ff [rcn_pkg::DIV_STEPS];
   rcn_pkg::div_stage_type first;

   // Rounding to nearest is folded in: (2*mag*2^14 + r) / (2*r).
   always_comb begin
      first.valid = in_stage.valid;
      first.rem_c = {1'b0, in_stage.side.ux, 15'd0} + 48'(in_stage.res[31:0]);
      first.rem_s = {1'b0, in_stage.side.uy, 15'd0} + 48'(in_stage.res[31:0]);
      first.q_c   = 15'd0;
      first.q_s   = 15'd0;
      first.d     = {in_stage.res[31:0], 1'b0};
      first.x_neg = in_stage.side.x_neg;
      first.y_neg = in_stage.side.y_neg;
      first.degen = in_stage.side.degen;
   end

   for (genvar j = 0; j < rcn_pkg::DIV_STEPS; j++) begin : g_step
      localparam int K = rcn_pkg::DIV_STEPS - 1 - j;
      rcn_pkg::div_stage_type cur;
      rcn_pkg::div_stage_type nxt_in;
      logic [47:0]            dsh;

      if (j == 0) begin : g_first
         assign cur = first;
      end else begin : g_rest
         assign cur = stg_ff[j - 1];
      end

      always_comb begin
         nxt_in = cur;
         dsh    = 48'(cur.d) << K;
         if (cur.rem_c >= dsh) begin
            nxt_in.rem_c  = cur.rem_c - dsh;
            nxt_in.q_c[K] = 1'b1;
         end
         if (cur.rem_s >= dsh) begin
            nxt_in.rem_s  = cur.rem_s - dsh;
            nxt_in.q_s[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[j] <= '0;
         end else begin
            stg_ff[j] <= nxt_in;
         end
      end
   end

   assign out_stage = stg_ff[rcn_pkg::DIV_STEPS - 1];

endmodule

// ----- rtl/core/rotation_compose_normalize_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_compose_normalize_top: compose two rotations and renormalize
// Complex multiply of two Q2.14 cos/sin pairs, then division by the
// magnitude, with an identity fallback at or below the epsilon register.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Direction  Handshake
//   request   start, busy, req_data         in         start & !busy
//   response  rsp_valid, rsp_data           out        strobe, one cycle
//   csr       csr_we, csr_wdata             in         write on csr_we
//
// A beat is taken in every cycle; busy is always low because nothing in the
// datapath can back up. In order, each taken beat then passes through
// four front stages (products, sums, squares, threshold compare), 32 root
// stages that each settle one bit of the square root, 15 divider stages that
// each settle one quotient bit for both parts, and the output register.
// Reset clears the valid bits of every stage and the epsilon register.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module rotation_compose_normalize_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rcn_pkg::req_type req_data,
   output logic             rsp_valid,
   output rcn_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [14:0]      csr_wdata
);

   logic [14:0] eps_ff;

   rcn_pkg::sq_stage_type  front_out;
   rcn_pkg::sq_stage_type  sqrt_out;
   rcn_pkg::div_stage_type div_out;

   logic             rsp_valid_ff;
   rcn_pkg::rsp_type rsp_data_ff;
   rcn_pkg::rsp_type rsp_data_in;

   // The pipeline accepts a beat every cycle.
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 15'd0;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   rcn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .epsilon   (eps_ff),
      .out_stage (front_out)
   );

   rcn_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (front_out),
      .out_stage (sqrt_out)
   );

   rcn_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (sqrt_out),
      .out_stage (div_out)
   );

   // Reapply the signs, or substitute the identity for a degenerate vector.
   always_comb begin
      if (div_out.degen) begin
         rsp_data_in.out_cos    = rcn_pkg::ONE_Q14;
         rsp_data_in.out_sin    = 16'sd0;
         rsp_data_in.degenerate = 1'b1;
      end else begin
         rsp_data_in.out_cos    = div_out.x_neg ? -$signed({1'b0, div_out.q_c})
                                                : $signed({1'b0, div_out.q_c});
         rsp_data_in.out_sin    = div_out.y_neg ? -$signed({1'b0, div_out.q_s})
                                                : $signed({1'b0, div_out.q_s});
         rsp_data_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_out.valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every response traces back to a request taken a fixed latency earlier.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, rcn_pkg::TOTAL_LAT))
      else $error("response without a matching request");

   // The identity fallback carries exactly cos 1, sin 0.
   a_identity : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.out_cos == rcn_pkg::ONE_Q14 && rsp_data.out_sin == 16'sd0))
      else $error("degenerate result is not the identity");

   // A normalized part never exceeds one in magnitude.
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_cos <= 16'sd16384 && rsp_data.out_cos >= -16'sd16384
                  && rsp_data.out_sin <= 16'sd16384 && rsp_data.out_sin >= -16'sd16384))
      else $error("normalized output out of range");

endmodule
